// ----- src/itcr_pkg.sv -----
package itcr_pkg;

  localparam int MAX_REGIONS_DEF = 1024;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_REMAP = 1'b1
  } op_t;

  // one queued request; a remap carries its segment in the chrom/a/b slots
  typedef struct packed {
    op_t         op;
    logic [9:0]  idx;
    logic [7:0]  chrom;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } req_t;

  typedef struct packed {
    logic [7:0]  chrom;
    logic [31:0] rstart;
    logic [31:0] rend;
    logic [31:0] equiv;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD1,
    ST_WALK,
    ST_FIN
  } state_t;

endpackage

// ----- src/itcr_front.sv -----
module itcr_front #(
  parameter int MAX_REGIONS = itcr_pkg::MAX_REGIONS_DEF
) (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [191:0]         s_tdata,
  input  logic                 s_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output itcr_pkg::req_t       q_data
);

  logic [31:0] idx32;
  logic        drop;

  assign idx32 = {22'd0, s_tdata[9:0]};
  // loads to slots beyond the table are accepted and discarded
  assign drop = (itcr_pkg::op_t'(s_tuser) == itcr_pkg::OP_LOAD) &&
                (idx32 >= 32'(MAX_REGIONS));

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full && !drop;

  always_comb begin
    q_data.op  = itcr_pkg::op_t'(s_tuser);
    q_data.idx = s_tdata[9:0];
    if (itcr_pkg::op_t'(s_tuser) == itcr_pkg::OP_LOAD) begin
      q_data.chrom = s_tdata[17:10];
      q_data.a     = s_tdata[49:18];
      q_data.b     = s_tdata[81:50];
      q_data.c     = s_tdata[113:82];
    end else begin
      q_data.chrom = s_tdata[121:114];
      q_data.a     = s_tdata[153:122];
      q_data.b     = s_tdata[185:154];
      q_data.c     = '0;
    end
  end

endmodule

// ----- src/itcr_queue.sv -----
module itcr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  itcr_pkg::req_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output itcr_pkg::req_t rdata
);

  localparam int PW = $clog2(itcr_pkg::QUEUE_DEPTH);

  itcr_pkg::req_t mem [itcr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wp, rp;
  logic [PW:0]    cnt;

  assign full  = cnt == (PW+1)'(itcr_pkg::QUEUE_DEPTH);
  assign empty = cnt == '0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == PW'(itcr_pkg::QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == PW'(itcr_pkg::QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ----- src/itcr_back.sv -----
module itcr_back #(
  parameter int MAX_REGIONS = itcr_pkg::MAX_REGIONS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic [10:0]    cfg_data,
  input  logic           q_empty,
  input  itcr_pkg::req_t q_data,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [71:0]    m_tdata,
  output logic           m_tuser
);

  localparam int AW = $clog2(MAX_REGIONS);
  localparam int W  = 34 + AW;

  itcr_pkg::entry_t mem [MAX_REGIONS];
  itcr_pkg::entry_t rdata, prev, cur, cur_next, prev_next;
  logic [AW-1:0]    ra, wa;
  logic             we;
  logic [31:0]      wa32;

  itcr_pkg::state_t state, state_next;
  logic [10:0]      count;
  logic [AW:0]      n, k, k_next, k1, k2;
  logic [7:0]       chrom, chrom_next;
  logic signed [W-1:0] s, e, s_next, e_next, s2, e2;
  logic             f1, f2, f1_next, f2_next, unmapped, unmapped_next;
  logic             done, match, first, last, has_next, ld_out;
  logic signed [W-1:0] c_start, c_end, c_eq, n_start, p_end;

  function automatic logic signed [W-1:0] ext(input logic [31:0] v);
    ext = $signed({{(W-32){1'b0}}, v});
  endfunction

  function automatic logic [32:0] sat(input logic signed [W-1:0] v);
    if (v[W-1:32] == '0 || v[W-1:32] == '1) sat = v[32:0];
    else if (v[W-1]) sat = {1'b1, 32'd0};
    else sat = {1'b0, 32'hFFFF_FFFF};
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= '{q_data.chrom, q_data.a, q_data.b, q_data.c};
    rdata <= mem[ra];
  end

  assign wa32 = {22'd0, q_data.idx};
  assign wa   = wa32[AW-1:0];
  assign n    = (32'(count) > 32'(MAX_REGIONS)) ? (AW+1)'(MAX_REGIONS) : (AW+1)'(count);
  assign k1   = k + 1'b1;
  assign k2   = k + 2'd2;

  assign c_start = ext(cur.rstart);
  assign c_end   = ext(cur.rend);
  assign c_eq    = ext(cur.equiv);
  assign n_start = ext(rdata.rstart);
  assign p_end   = ext(prev.rend);

  assign match    = cur.chrom == chrom;
  assign first    = (k == '0) || (prev.chrom != chrom);
  assign has_next = k1 < n;
  assign last     = !has_next || (rdata.chrom != chrom);
  assign ld_out   = (state == itcr_pkg::ST_FIN) && (!m_tvalid || m_tready);

  always_comb begin
    state_next    = state;
    k_next        = k;
    chrom_next    = chrom;
    s_next        = s;
    e_next        = e;
    f1_next       = f1;
    f2_next       = f2;
    unmapped_next = unmapped;
    prev_next     = prev;
    cur_next      = cur;
    q_pop         = 1'b0;
    we            = 1'b0;
    ra            = '0;
    done          = 1'b0;
    s2            = s;
    e2            = e;
    case (state)
      itcr_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.op == itcr_pkg::OP_LOAD) begin
            we = 1'b1;
          end else begin
            chrom_next    = q_data.chrom;
            s_next        = ext(q_data.a);
            e_next        = ext(q_data.b);
            f1_next       = 1'b0;
            f2_next       = 1'b0;
            k_next        = '0;
            unmapped_next = 1'b1;
            state_next    = (n == '0) ? itcr_pkg::ST_FIN : itcr_pkg::ST_RD1;
          end
        end
      end
      itcr_pkg::ST_RD1: begin
        cur_next   = rdata;
        ra         = AW'(1);
        state_next = itcr_pkg::ST_WALK;
      end
      itcr_pkg::ST_WALK: begin
        ra = k2[AW-1:0];
        if (match) begin
          if (first && (s < c_start || (f1 && f2))) begin
            done = 1'b1;
          end else if (has_next && s > c_end && s < n_start) begin
            s2 = s - c_end + c_eq;
            e2 = e - c_end + c_eq;
            done = 1'b1;
          end else if (k != '0 && s > p_end && s < c_start) begin
            s2 = s - p_end + ext(prev.equiv);
            e2 = e - p_end + ext(prev.equiv);
            done = 1'b1;
          end else if (s >= c_start && s <= c_end) begin
            s2 = c_eq;
            e2 = e - c_end + c_eq;
            done = 1'b1;
          end else if (f1 && f2) begin
            done = 1'b1;
          end else if (last) begin
            // end of the chromosome run: shift what lies past the region end
            if (s >= c_end) begin
              s2 = s - c_end + c_eq;
              f1_next = 1'b1;
            end
            if (e >= c_end) begin
              e2 = e - c_end + c_eq;
              f2_next = 1'b1;
            end
            if (f1_next && f2_next && s2 <= e2) done = 1'b1;
          end
        end
        s_next = s2;
        e_next = e2;
        if (done) begin
          unmapped_next = 1'b0;
          state_next    = itcr_pkg::ST_FIN;
        end else if (k1 == n) begin
          state_next = itcr_pkg::ST_FIN;
        end else begin
          k_next    = k1;
          prev_next = cur;
          cur_next  = rdata;
        end
      end
      itcr_pkg::ST_FIN: begin
        if (ld_out) state_next = itcr_pkg::ST_IDLE;
      end
      default: state_next = itcr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= itcr_pkg::ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) count <= cfg_data;
      if (ld_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    k        <= k_next;
    chrom    <= chrom_next;
    s        <= s_next;
    e        <= e_next;
    f1       <= f1_next;
    f2       <= f2_next;
    unmapped <= unmapped_next;
    prev     <= prev_next;
    cur      <= cur_next;
    if (ld_out) begin
      m_tdata <= {6'd0, sat(e), sat(s)};
      m_tuser <= unmapped;
    end
  end

`ifndef SYNTHESIS
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    state == itcr_pkg::ST_WALK |-> k < n)
    else $error("walk index past region count");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == itcr_pkg::ST_IDLE && !q_empty)
    else $error("queue popped outside idle");
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == itcr_pkg::ST_FIN && m_tvalid && !m_tready) |=> state == itcr_pkg::ST_FIN)
    else $error("result dropped while output stalled");
`endif

endmodule

// ----- src/interval_table_coordinate_remap_top.sv -----
// Interval table coordinate remapper.
// Slave stream s_*: s_tuser is op (0 load region, 1 remap segment); s_tdata
// carries the region entry and the segment fields. A load writes one table
// slot and gives no result; a remap gives one result on the master stream.
// Master stream m_*: m_tdata = new_start, new_end (33-bit two's complement,
// saturated), m_tuser = status (1 when no rule stopped the walk).
// cfg_*: writes region_count; write only while the block is idle.
// Requests pass through a 2-deep queue to the walk engine. The engine writes a
// load's entry into the table from its idle state. A remap primes the table
// read window in the idle and read states, then visits one table entry per
// cycle (up to region_count, at most MAX_REGIONS), then loads the output
// register. The engine takes no new request until a remap is through; the
// table has a single read port. If m_tready is low, the finished result
// waits in the engine and the queue keeps taking requests until full.
// Reset (rst, synchronous) clears region_count, the queue and the output
// valid; table contents are left undefined until loaded.
module interval_table_coordinate_remap_top #(
  parameter int MAX_REGIONS = itcr_pkg::MAX_REGIONS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // region_index, region_chrom, region_start, region_end, region_equiv_end,
  // seg_chrom, seg_start, seg_end, zero pad
  input  logic [191:0] s_tdata,
  // op
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_start, new_end, zero pad
  output logic [71:0]  m_tdata,
  // status
  output logic         m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [10:0]  cfg_data
);

  itcr_pkg::req_t push_data, pop_data;
  logic           push, full, pop, empty;

  assign cfg_ready = 1'b1;

  itcr_front #(.MAX_REGIONS(MAX_REGIONS)) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (full),
    .q_push   (push),
    .q_data   (push_data)
  );

  itcr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .rdata (pop_data)
  );

  itcr_back #(.MAX_REGIONS(MAX_REGIONS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_empty   (empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
